// File: rtl/core/vlmq_pkg.sv
package vlmq_pkg;

  localparam int unsigned LevelW   = 8;
  localparam int unsigned CountW   = 8;
  localparam int unsigned SampleW  = 2;
  localparam int unsigned CfgIdxW  = 3;

  typedef logic [CfgIdxW-1:0] cfg_idx_t;
  typedef logic [LevelW-1:0]  level_t;
  typedef logic [SampleW-1:0] sample_t;
  typedef logic [CountW-1:0]  count_t;

  // Configuration register indexes
  localparam cfg_idx_t CfgQualifyCount   = 3'd0;
  localparam cfg_idx_t CfgNightLevel     = 3'd1;
  localparam cfg_idx_t CfgRainWeakLevel  = 3'd2;
  localparam cfg_idx_t CfgRainStrongLevel = 3'd3;
  localparam cfg_idx_t CfgHighOnLevel    = 3'd4;

  // Reset values
  localparam count_t QualifyCountRst    = 8'd3;
  localparam level_t NightLevelRst      = 8'd178;
  localparam level_t RainWeakLevelRst   = 8'd178;
  localparam level_t RainStrongLevelRst = 8'd255;
  localparam level_t HighOnLevelRst     = 8'd255;

  // Corner request codes
  localparam logic [1:0] CornerOff   = 2'd0;
  localparam logic [1:0] CornerBoth  = 2'd1;
  localparam logic [1:0] CornerRight = 2'd2;
  localparam logic [1:0] CornerLeft  = 2'd3;

  typedef struct packed {
    count_t qualify_count;
    level_t night_level;
    level_t rain_weak_level;
    level_t rain_strong_level;
    level_t high_on_level;
  } cfg_t;

endpackage

// File: rtl/core/vehicle_light_mode_qualifier_unit.sv
// Light mode qualifier: debounces five sampled light mode requests (low beam,
// rain, high beam, fog, corner) and drives lamp levels and on/off lines.
//
// Channels: the input channel (in_valid_i/in_ready_o) carries one sample of all
// five requests per item; the output channel (out_valid_o/out_ready_i) returns
// exactly one result item per sample. A separate configuration write channel
// (cfg_valid_i/cfg_ready_o, cfg_index_i, cfg_data_i) sets the qualify count and
// the lamp levels; it is always ready and should only be written while idle.
//
// An accepted sample is loaded into the input register, then into the result
// register, which raises out_valid_o. Throughput is one item per cycle while
// the receiver does not stall, set by the single pass through the per-channel
// run counters.
//
// Reset clears all run counters, previous and confirmed modes and drives all
// levels and lamps off; the configuration returns to its default values.
// When the receiver stalls, the result register holds and the input register
// fills; once both are full in_ready_o drops until the result is taken.
module vehicle_light_mode_qualifier_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  // configuration
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  vlmq_pkg::cfg_idx_t cfg_index_i,
  input  vlmq_pkg::level_t  cfg_data_i,
  // input samples
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              low_beam_request_i,
  input  logic              rain_request_i,
  input  logic              high_beam_request_i,
  input  logic              fog_request_i,
  input  logic [1:0]        corner_request_i,
  // results
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output vlmq_pkg::level_t  low_beam_level_o,
  output logic              low_beam_write_o,
  output vlmq_pkg::level_t  high_beam_level_o,
  output logic              high_beam_write_o,
  output logic              fog_lamp_on_o,
  output logic              left_corner_on_o,
  output logic              right_corner_on_o
);
  import vlmq_pkg::*;

  cfg_t cfg;

  // Input register
  logic       in_vld_q;
  logic       low_s_q, rain_s_q, high_s_q, fog_s_q;
  logic [1:0] corner_s_q;

  // Result register; the lamp levels double as the drive state
  logic   out_vld_q;
  level_t low_lvl_q, low_lvl_d, high_lvl_q, high_lvl_d;
  logic   low_wr_q, high_wr_q;
  logic   fog_q, fog_d, left_q, left_d, right_q, right_d;

  logic out_free, advance;
  logic acc_low, acc_rain, acc_high, acc_fog, acc_corner;

  // Advance the held sample whenever the result register can take it.
  assign out_free   = !out_vld_q || out_ready_i;
  assign advance    = in_vld_q && out_free;
  assign in_ready_o = !in_vld_q || out_free;

  vlmq_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  vlmq_channel u_ch_low (
    .clk_i (clk_i), .rst_ni (rst_ni), .advance_i (advance),
    .sample_i ({1'b0, low_s_q}), .qualify_count_i (cfg.qualify_count),
    .accept_o (acc_low)
  );

  vlmq_channel u_ch_rain (
    .clk_i (clk_i), .rst_ni (rst_ni), .advance_i (advance),
    .sample_i ({1'b0, rain_s_q}), .qualify_count_i (cfg.qualify_count),
    .accept_o (acc_rain)
  );

  vlmq_channel u_ch_high (
    .clk_i (clk_i), .rst_ni (rst_ni), .advance_i (advance),
    .sample_i ({1'b0, high_s_q}), .qualify_count_i (cfg.qualify_count),
    .accept_o (acc_high)
  );

  vlmq_channel u_ch_fog (
    .clk_i (clk_i), .rst_ni (rst_ni), .advance_i (advance),
    .sample_i ({1'b0, fog_s_q}), .qualify_count_i (cfg.qualify_count),
    .accept_o (acc_fog)
  );

  vlmq_channel u_ch_corner (
    .clk_i (clk_i), .rst_ni (rst_ni), .advance_i (advance),
    .sample_i (corner_s_q), .qualify_count_i (cfg.qualify_count),
    .accept_o (acc_corner)
  );

  // Lamp drive update; rain is evaluated after low beam, so it wins a tie.
  always_comb begin
    low_lvl_d  = low_lvl_q;
    high_lvl_d = high_lvl_q;
    fog_d      = fog_q;
    left_d     = left_q;
    right_d    = right_q;
    if (acc_low) begin
      low_lvl_d = low_s_q ? cfg.night_level : '0;
    end
    if (acc_rain) begin
      low_lvl_d = rain_s_q ? cfg.rain_strong_level : cfg.rain_weak_level;
    end
    if (acc_high) begin
      high_lvl_d = high_s_q ? '0 : cfg.high_on_level;
    end
    if (acc_fog) begin
      fog_d = fog_s_q;
    end
    if (acc_corner) begin
      left_d  = (corner_s_q == CornerBoth) || (corner_s_q == CornerLeft);
      right_d = (corner_s_q == CornerBoth) || (corner_s_q == CornerRight);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      low_s_q    <= low_beam_request_i;
      rain_s_q   <= rain_request_i;
      high_s_q   <= high_beam_request_i;
      fog_s_q    <= fog_request_i;
      corner_s_q <= corner_request_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      low_lvl_q  <= '0;
      high_lvl_q <= '0;
      low_wr_q   <= 1'b0;
      high_wr_q  <= 1'b0;
      fog_q      <= 1'b0;
      left_q     <= 1'b0;
      right_q    <= 1'b0;
    end else begin
      if (out_free) begin
        out_vld_q <= in_vld_q;
      end
      if (advance) begin
        low_lvl_q  <= low_lvl_d;
        high_lvl_q <= high_lvl_d;
        low_wr_q   <= acc_low || acc_rain;
        high_wr_q  <= acc_high;
        fog_q      <= fog_d;
        left_q     <= left_d;
        right_q    <= right_d;
      end
    end
  end

  assign out_valid_o       = out_vld_q;
  assign low_beam_level_o  = low_lvl_q;
  assign low_beam_write_o  = low_wr_q;
  assign high_beam_level_o = high_lvl_q;
  assign high_beam_write_o = high_wr_q;
  assign fog_lamp_on_o     = fog_q;
  assign left_corner_on_o  = left_q;
  assign right_corner_on_o = right_q;

endmodule

// File: rtl/core/vlmq_cfg_regs.sv
module vlmq_cfg_regs (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  vlmq_pkg::cfg_idx_t cfg_index_i,
  input  vlmq_pkg::level_t  cfg_data_i,
  output vlmq_pkg::cfg_t    cfg_o
);
  import vlmq_pkg::*;

  cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgQualifyCount:    cfg_d.qualify_count     = cfg_data_i;
        CfgNightLevel:      cfg_d.night_level       = cfg_data_i;
        CfgRainWeakLevel:   cfg_d.rain_weak_level   = cfg_data_i;
        CfgRainStrongLevel: cfg_d.rain_strong_level = cfg_data_i;
        CfgHighOnLevel:     cfg_d.high_on_level     = cfg_data_i;
        default:            cfg_d = cfg_q;  // drop writes to unused indexes
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.qualify_count     <= QualifyCountRst;
      cfg_q.night_level       <= NightLevelRst;
      cfg_q.rain_weak_level   <= RainWeakLevelRst;
      cfg_q.rain_strong_level <= RainStrongLevelRst;
      cfg_q.high_on_level     <= HighOnLevelRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: rtl/core/vlmq_channel.sv
module vlmq_channel (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              advance_i,
  input  vlmq_pkg::sample_t sample_i,
  input  vlmq_pkg::count_t  qualify_count_i,
  output logic              accept_o
);
  import vlmq_pkg::*;

  sample_t prev_q, conf_q;
  logic    prev_valid_q, conf_valid_q;
  count_t  count_q, count_d, run;

  // Restart the run on a changed or first sample, else extend it (wraps).
  assign run = (!prev_valid_q || prev_q != sample_i) ? count_t'(1) : count_q + count_t'(1);
  assign accept_o = (run >= qualify_count_i) && (!conf_valid_q || conf_q != sample_i);
  assign count_d  = accept_o ? '0 : run;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q       <= '0;
      prev_valid_q <= 1'b0;
      count_q      <= '0;
      conf_q       <= '0;
      conf_valid_q <= 1'b0;
    end else if (advance_i) begin
      prev_q       <= sample_i;
      prev_valid_q <= 1'b1;
      count_q      <= count_d;
      if (accept_o) begin
        conf_q       <= sample_i;
        conf_valid_q <= 1'b1;
      end
    end
  end

endmodule

// File: sim/testbench.sv
`timescale 1ns / 1ps

// Light mode qualifier testbench.
//
// A clocked driver feeds light mode samples from a pending queue, and a
// clocked scoreboard predicts each lamp result at the moment the sample is
// taken. It then checks the returned results, in order, field by field.
// The stimulus starts with a short directed burst at the reset configuration.
// It then runs through phases, each with its own qualify count and lamp
// levels. Registers are only reprogrammed once the block has drained.
module testbench;
  import vlmq_pkg::*;

  // Predictor channel order: low beam and rain share the low beam level, and
  // rain is evaluated second so it wins a same-sample tie.
  typedef enum int {
    ChLow,
    ChRain,
    ChHigh,
    ChFog,
    ChCorner
  } lamp_ch_e;

  localparam int unsigned NumCh = 5;
  localparam cfg_idx_t FirstUnusedIdx = CfgHighOnLevel + cfg_idx_t'(1);

  typedef struct packed {
    logic    low;
    logic    rain;
    logic    high;
    logic    fog;
    sample_t corner;
  } light_sample_t;

  typedef struct packed {
    level_t low_level;
    logic   low_wr;
    level_t high_level;
    logic   high_wr;
    logic   fog;
    logic   left;
    logic   right;
  } lamp_result_t;

  typedef struct packed {
    cfg_idx_t idx;
    level_t   data;
  } cfg_write_t;

  // Clock, reset and block ports; every input starts at a known value.
  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     cfg_valid_i = 1'b0;
  logic     cfg_ready_o;
  cfg_idx_t cfg_index_i = '0;
  level_t   cfg_data_i = '0;
  logic     in_valid_i = 1'b0;
  logic     in_ready_o;
  logic     low_beam_request_i = 1'b0;
  logic     rain_request_i = 1'b0;
  logic     high_beam_request_i = 1'b0;
  logic     fog_request_i = 1'b0;
  logic     [1:0] corner_request_i = 2'b00;
  logic     out_valid_o;
  logic     out_ready_i = 1'b0;
  level_t   low_beam_level_o;
  logic     low_beam_write_o;
  level_t   high_beam_level_o;
  logic     high_beam_write_o;
  logic     fog_lamp_on_o;
  logic     left_corner_on_o;
  logic     right_corner_on_o;

  // Pending stimulus, expected lamp results and error count.
  light_sample_t sample_q[$];
  cfg_write_t    cfg_q[$];
  lamp_result_t  lamp_expect[$];
  int unsigned   errors = 0;
  logic          no_gaps = 1'b0;

  // Predictor state: register copy, per-channel run tracking, lamp drive.
  cfg_t    regs = '{QualifyCountRst, NightLevelRst, RainWeakLevelRst,
                    RainStrongLevelRst, HighOnLevelRst};
  sample_t last_sample[NumCh] = '{default: '0};
  logic    last_seen[NumCh] = '{default: 1'b0};
  count_t  run_len[NumCh] = '{default: '0};
  sample_t held_mode[NumCh] = '{default: '0};
  logic    held_ok[NumCh] = '{default: 1'b0};
  level_t  lamp_low = '0;
  level_t  lamp_high = '0;
  logic    lamp_fog = 1'b0;
  logic    lamp_left = 1'b0;
  logic    lamp_right = 1'b0;

  vehicle_light_mode_qualifier_unit dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .low_beam_request_i (low_beam_request_i),
    .rain_request_i     (rain_request_i),
    .high_beam_request_i(high_beam_request_i),
    .fog_request_i      (fog_request_i),
    .corner_request_i   (corner_request_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .low_beam_level_o   (low_beam_level_o),
    .low_beam_write_o   (low_beam_write_o),
    .high_beam_level_o  (high_beam_level_o),
    .high_beam_write_o  (high_beam_write_o),
    .fog_lamp_on_o      (fog_lamp_on_o),
    .left_corner_on_o   (left_corner_on_o),
    .right_corner_on_o  (right_corner_on_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Advance one channel's run; return 1 when the sample becomes the held mode.
  // Run length is 8 bits and wraps on a long run of equal samples.
  function automatic logic accept_mode(lamp_ch_e ch, sample_t s);
    if (!last_seen[ch] || last_sample[ch] != s) run_len[ch] = '0;
    run_len[ch] = run_len[ch] + count_t'(1);
    last_sample[ch] = s;
    last_seen[ch] = 1'b1;
    if (run_len[ch] >= regs.qualify_count && (!held_ok[ch] || held_mode[ch] != s)) begin
      held_mode[ch] = s;
      held_ok[ch] = 1'b1;
      run_len[ch] = '0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Work out the lamp result of one accepted sample. Levels are latched from
  // the registers only when a mode is accepted.
  function automatic lamp_result_t predict_lamps(light_sample_t smp);
    lamp_result_t r;
    r.low_wr = 1'b0;
    r.high_wr = 1'b0;
    if (accept_mode(ChLow, sample_t'(smp.low))) begin
      lamp_low = smp.low ? regs.night_level : '0;
      r.low_wr = 1'b1;
    end
    if (accept_mode(ChRain, sample_t'(smp.rain))) begin
      lamp_low = smp.rain ? regs.rain_strong_level : regs.rain_weak_level;
      r.low_wr = 1'b1;
    end
    if (accept_mode(ChHigh, sample_t'(smp.high))) begin
      lamp_high = smp.high ? '0 : regs.high_on_level;
      r.high_wr = 1'b1;
    end
    if (accept_mode(ChFog, sample_t'(smp.fog))) lamp_fog = smp.fog;
    if (accept_mode(ChCorner, smp.corner)) begin
      lamp_left = (smp.corner == CornerBoth) || (smp.corner == CornerLeft);
      lamp_right = (smp.corner == CornerBoth) || (smp.corner == CornerRight);
    end
    r.low_level = lamp_low;
    r.high_level = lamp_high;
    r.fog = lamp_fog;
    r.left = lamp_left;
    r.right = lamp_right;
    return r;
  endfunction

  task automatic check_field(string what, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      errors++;
    end
  endtask

  // Sample driver: hold valid and payload until taken, then load the next
  // item or idle at random.
  always @(posedge clk_i or negedge rst_ni) begin : sample_drive
    light_sample_t nxt;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || in_ready_o) begin
      if (sample_q.size() != 0 && (no_gaps || $urandom_range(99) >= 33)) begin
        nxt = sample_q.pop_front();
        in_valid_i <= 1'b1;
        low_beam_request_i <= nxt.low;
        rain_request_i <= nxt.rain;
        high_beam_request_i <= nxt.high;
        fog_request_i <= nxt.fog;
        corner_request_i <= nxt.corner;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Register write driver.
  always @(posedge clk_i or negedge rst_ni) begin : cfg_drive
    cfg_write_t w;
    if (!rst_ni) begin
      cfg_valid_i <= 1'b0;
    end else if (!cfg_valid_i || cfg_ready_o) begin
      if (cfg_q.size() != 0) begin
        w = cfg_q.pop_front();
        cfg_valid_i <= 1'b1;
        cfg_index_i <= w.idx;
        cfg_data_i <= w.data;
      end else begin
        cfg_valid_i <= 1'b0;
      end
    end
  end

  // Scoreboard: stall the result side at random, track register writes,
  // check returned results and predict newly accepted samples.
  always @(posedge clk_i or negedge rst_ni) begin : scoreboard
    lamp_result_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= no_gaps || ($urandom_range(99) >= 33);
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CfgQualifyCount:    regs.qualify_count = cfg_data_i;
          CfgNightLevel:      regs.night_level = cfg_data_i;
          CfgRainWeakLevel:   regs.rain_weak_level = cfg_data_i;
          CfgRainStrongLevel: regs.rain_strong_level = cfg_data_i;
          CfgHighOnLevel:     regs.high_on_level = cfg_data_i;
          default: ;
        endcase
      end
      if (out_valid_o && out_ready_i) begin
        if (lamp_expect.size() == 0) begin
          $display("%0t: result with no sample pending, low %0d high %0d", $time,
                   low_beam_level_o, high_beam_level_o);
          errors++;
        end else begin
          want = lamp_expect.pop_front();
          check_field("low_beam_level", want.low_level, low_beam_level_o);
          check_field("low_beam_write", want.low_wr, low_beam_write_o);
          check_field("high_beam_level", want.high_level, high_beam_level_o);
          check_field("high_beam_write", want.high_wr, high_beam_write_o);
          check_field("fog_lamp_on", want.fog, fog_lamp_on_o);
          check_field("left_corner_on", want.left, left_corner_on_o);
          check_field("right_corner_on", want.right, right_corner_on_o);
        end
      end
      if (in_valid_i && in_ready_o) begin
        lamp_expect.push_back(predict_lamps('{low_beam_request_i, rain_request_i,
                                              high_beam_request_i, fog_request_i,
                                              corner_request_i}));
      end
    end
  end

  // Wait until the block has drained: nothing queued, nothing in flight.
  task automatic wait_idle();
    @(negedge clk_i);
    while (sample_q.size() != 0 || cfg_q.size() != 0 || in_valid_i || cfg_valid_i ||
           lamp_expect.size() != 0)
      @(negedge clk_i);
  endtask

  task automatic push_sample(logic low, logic rain, logic high, logic fog,
                             sample_t corner, int unsigned reps);
    repeat (reps) sample_q.push_back('{low, rain, high, fog, corner});
  endtask

  // Per-channel runs of equal samples with random length, plus short noise
  // runs that break a qualification.
  task automatic push_runs(int unsigned n, int unsigned min_run, int unsigned max_run);
    sample_t     cur[NumCh];
    int unsigned left_in_run[NumCh];
    for (int c = 0; c < NumCh; c++) left_in_run[c] = 0;
    repeat (n) begin
      for (int c = 0; c < NumCh; c++) begin
        if (left_in_run[c] == 0) begin
          cur[c] = (c == ChCorner) ? sample_t'($urandom_range(3)) : sample_t'($urandom_range(1));
          left_in_run[c] = ($urandom_range(99) < 15) ? 1 : $urandom_range(max_run, min_run);
        end
        left_in_run[c]--;
      end
      sample_q.push_back('{cur[ChLow][0], cur[ChRain][0], cur[ChHigh][0], cur[ChFog][0],
                           cur[ChCorner]});
    end
  endtask

  initial begin : stimulus
    count_t      qual_plan[8];
    count_t      qual;
    level_t      lvl;
    int unsigned hi;
    qual_plan = '{8'd0, 8'd1, 8'd255, 8'd2, 8'd3, 8'd5, 8'd0, 8'd1};
    qual_plan[5] = count_t'($urandom_range(8, 1));
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset configuration, qualify count of three.
    push_sample(1'b0, 1'b0, 1'b0, 1'b0, CornerOff, 3);    // first confirm: day, weak, on
    push_sample(1'b1, 1'b1, 1'b1, 1'b1, CornerBoth, 3);   // low and rain tie, rain wins
    push_sample(1'b1, 1'b0, 1'b0, 1'b1, CornerRight, 3);  // rain alone rewrites the level
    push_sample(1'b0, 1'b0, 1'b0, 1'b1, CornerLeft, 2);   // run broken one short
    push_sample(1'b0, 1'b0, 1'b0, 1'b1, CornerRight, 1);
    push_sample(1'b0, 1'b0, 1'b1, 1'b0, CornerLeft, 3);
    push_sample(1'b1, 1'b1, 1'b0, 1'b0, CornerOff, 3);

    for (int p = 0; p < 8; p++) begin
      wait_idle();
      qual = qual_plan[p];
      cfg_q.push_back('{CfgQualifyCount, qual});
      // Extremes first: all levels zero, then all full scale, then random.
      lvl = (p == 0) ? '0 : (p == 1) ? '1 : level_t'($urandom_range(255));
      cfg_q.push_back('{CfgNightLevel, lvl});
      lvl = (p == 0) ? '0 : (p == 1) ? '1 : level_t'($urandom_range(255));
      cfg_q.push_back('{CfgRainWeakLevel, lvl});
      lvl = (p == 0) ? '0 : (p == 1) ? '1 : level_t'($urandom_range(255));
      cfg_q.push_back('{CfgRainStrongLevel, lvl});
      lvl = (p == 0) ? '0 : (p == 1) ? '1 : level_t'($urandom_range(255));
      cfg_q.push_back('{CfgHighOnLevel, lvl});
      // Writes to an unused index must leave every register alone.
      cfg_q.push_back('{FirstUnusedIdx + cfg_idx_t'(p % 3), level_t'($urandom_range(255))});
      wait_idle();
      no_gaps = (p == 4);
      if (qual == count_t'(255)) begin
        // Long runs reach the full count and wrap.
        push_runs(600, 250, 300);
      end else begin
        hi = (qual < 2) ? 3 : qual + 2;
        push_runs(160, 1, hi);
      end
    end

    wait_idle();
    no_gaps = 1'b0;
    repeat (10) @(negedge clk_i);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
